/* rtl/round_filtered_step_chaser_core_defines.svh */
// assertion macros used by the step chaser engine
`ifndef ROUND_FILTERED_STEP_CHASER_CORE_DEFINES_SVH
`define ROUND_FILTERED_STEP_CHASER_CORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define RFSC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RFSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/rfsc_pkg.sv */
// shared types and constants of the step chaser
package rfsc_pkg;

	localparam int DUR_W     = 16;
	localparam int LIM_W     = 16;
	localparam int RN_W      = 15;
	localparam int ELAPSED_W = 17;
	localparam int POS_W     = 5;
	localparam int CNT_W     = 5;
	localparam int STEP_W    = 4;

	localparam logic [LIM_W-1:0] NO_LIMIT = '1;
	localparam logic [RN_W-1:0]  RN_TOP   = '1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_PLAY  = 2'd1,
		OP_STOP  = 2'd2,
		OP_WRITE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		EV_ACT        = 2'd0,
		EV_DEACT      = 2'd1,
		EV_NONE_FOUND = 2'd2
	} kind_t;

	typedef struct packed {
		logic [DUR_W-1:0] dur;
		logic [LIM_W-1:0] min_r;
		logic [LIM_W-1:0] exact_r;
		logic [LIM_W-1:0] max_r;
		logic [1:0]       flags;   // bit 0 activate, bit 1 deactivate
	} entry_t;

	typedef struct packed {
		op_t               op;
		logic [STEP_W-1:0] index;
		entry_t            entry;
	} cmd_t;

	typedef struct packed {
		kind_t             kind;
		logic [STEP_W-1:0] step;
		logic [RN_W-1:0]   rnum;
		logic              last;
	} result_t;

endpackage

/* rtl/round_filtered_step_chaser_core.sv */
// Lighting step chaser. Commands arrive on the slave stream (tuser selects tick, play, stop or
// table write); a front register and a two-entry command queue decouple input from the engine,
// so new transfers are taken while events wait on the master stream. A table write is done as
// the engine takes it from the queue. A tick while playing reads the current step and ends there
// when that step keeps running; otherwise the eligibility search reads one table entry per cycle
// from the step table, trying at most SEARCH_LIMIT candidates, and its events are then emitted
// one by one. Play runs the same search from step 0; stop reads the current step and emits its
// deactivate event if flagged. Commands pass through the front register and then the queue
// before the engine. Table entries read before being written give undefined events.
module round_filtered_step_chaser_core import rfsc_pkg::*; #(
	parameter int MAX_STEPS    = 16,
	parameter int SEARCH_LIMIT = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,      // step_count
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [1:0]       s_tuser,        // opcode
	// step_index[3:0], duration_ms[19:4], min_round_in[35:20], exact_round_in[51:36],
	// max_round_in[67:52], activate_flag_in[68], deactivate_flag_in[69], zero fill
	input  logic [71:0]      s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [1:0]       m_tuser,        // event_kind
	output logic [23:0]      m_tdata,        // event_step[3:0], round_number[18:4], zero fill
	output logic             m_tlast
);

	logic    fr_valid;
	logic    fr_ready;
	cmd_t    fr_cmd;
	logic    q_valid;
	logic    q_pop;
	cmd_t    q_cmd;
	result_t res;

	rfsc_front #(
		.MAX_STEPS(MAX_STEPS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.cmd_valid (fr_valid),
		.cmd_ready (fr_ready),
		.cmd       (fr_cmd)
	);

	rfsc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_cmd    (fr_cmd),
		.out_valid (q_valid),
		.out_pop   (q_pop),
		.out_cmd   (q_cmd)
	);

	rfsc_engine #(
		.MAX_STEPS    (MAX_STEPS),
		.SEARCH_LIMIT (SEARCH_LIMIT)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd_valid (q_valid),
		.cmd_pop   (q_pop),
		.cmd       (q_cmd),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tuser = res.kind;
	assign m_tdata = {5'b0, res.rnum, res.step};
	assign m_tlast = res.last;

endmodule

/* rtl/rfsc_front.sv */
// front end: accepts input transfers, decodes them into commands
module rfsc_front import rfsc_pkg::*; #(
	parameter int MAX_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,
	input  logic [71:0] s_tdata,
	output logic        cmd_valid,
	input  logic        cmd_ready,
	output cmd_t        cmd
);

	logic accept;
	logic drop;
	cmd_t dec;
	logic vld_s1;
	cmd_t cmd_s1;

	always_comb begin
		dec.op            = op_t'(s_tuser);
		dec.index         = s_tdata[3:0];
		dec.entry.dur     = s_tdata[19:4];
		dec.entry.min_r   = s_tdata[35:20];
		dec.entry.exact_r = s_tdata[51:36];
		dec.entry.max_r   = s_tdata[67:52];
		dec.entry.flags   = s_tdata[69:68];
	end

	// writes beyond the table are discarded here
	assign drop = (dec.op == OP_WRITE) && (32'(dec.index) >= 32'(MAX_STEPS));

	assign s_tready = !vld_s1 || cmd_ready;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= !drop;
		end else if (cmd_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= dec;
		end
	end

	assign cmd_valid = vld_s1;
	assign cmd       = cmd_s1;

endmodule

/* rtl/rfsc_queue.sv */
// short command queue between front and engine
module rfsc_queue import rfsc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  cmd_t in_cmd,
	output logic out_valid,
	input  logic out_pop,
	output cmd_t out_cmd
);

	cmd_t              slots [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign in_ready  = count_q != QCNT_W'(QUEUE_DEPTH);
	assign out_valid = count_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_pop && out_valid;
	assign out_cmd   = slots[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots[wr_ptr_q] <= in_cmd;
		end
	end

endmodule

/* rtl/rfsc_engine.sv */
// back end: step table, play state, eligibility search and event output
`include "round_filtered_step_chaser_core_defines.svh"

module rfsc_engine import rfsc_pkg::*; #(
	parameter int MAX_STEPS    = 16,
	parameter int SEARCH_LIMIT = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	input  logic             cmd_valid,
	output logic             cmd_pop,
	input  cmd_t             cmd,
	output logic             res_valid,
	input  logic             res_ready,
	output result_t          res
);

	localparam int IDX_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
	localparam int SL_W  = $clog2(SEARCH_LIMIT);

	typedef enum logic [4:0] {
		S_IDLE    = 5'b00001,
		S_TICK_RD = 5'b00010,
		S_STOP_RD = 5'b00100,
		S_SEARCH  = 5'b01000,
		S_EMIT    = 5'b10000
	} state_t;

	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic [RN_W-1:0]  rn;
	} cand_t;

	function automatic cand_t next_cand(input logic [POS_W-1:0] pos,
		input logic [RN_W-1:0] rn, input logic [CNT_W-1:0] cnt);
		cand_t            c;
		logic [POS_W:0]   p1;
		p1 = {1'b0, pos} + 1'b1;
		// wrap also covers a position left beyond a reduced step count
		c.pos = (p1 >= {1'b0, cnt}) ? '0 : p1[POS_W-1:0];
		c.rn  = ((c.pos == '0) && (rn != RN_TOP)) ? rn + 1'b1 : rn;
		return c;
	endfunction

	function automatic logic eligible(input entry_t e, input logic [RN_W-1:0] rn);
		logic signed [LIM_W:0] r;
		logic                  ok_min;
		logic                  ok_exact;
		logic                  ok_max;
		r        = $signed({2'b00, rn});
		ok_min   = (e.min_r == NO_LIMIT) || (r >= $signed({e.min_r[LIM_W-1], e.min_r}));
		ok_exact = (e.exact_r == NO_LIMIT) || (r == $signed({e.exact_r[LIM_W-1], e.exact_r}));
		ok_max   = (e.max_r == NO_LIMIT) || (r <= $signed({e.max_r[LIM_W-1], e.max_r}));
		return ok_min && ok_exact && ok_max;
	endfunction

	entry_t mem [MAX_STEPS];
	entry_t rd_q;
	logic [IDX_W-1:0] rd_addr;
	logic             mem_we;

	state_t               state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 playing_q;
	logic [POS_W-1:0]     cur_q;
	logic [RN_W-1:0]      rn_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic [POS_W-1:0]     pos_iss_q;
	logic [RN_W-1:0]      rn_iss_q;
	logic [SL_W-1:0]      chk_q;
	logic [POS_W-1:0]     old_pos_q;
	logic [DUR_W-1:0]     old_dur_q;
	logic [1:0]           old_flags_q;
	logic                 is_tick_q;
	result_t              pend0_q;
	result_t              pend1_q;
	logic [1:0]           pend_n_q;
	logic                 out_vld_q;
	result_t              out_q;

	cand_t   tick_start;
	cand_t   nxt;
	logic    slot_free;
	logic    emit_load;
	logic    hit;
	logic    act_ev;
	logic    deact_ev;

	assign tick_start = next_cand(cur_q, rn_q, cnt_q);
	assign nxt        = next_cand(pos_iss_q, rn_iss_q, cnt_q);
	assign slot_free  = !out_vld_q || res_ready;
	assign emit_load  = (state_q == S_EMIT) && slot_free;
	assign cmd_pop    = (state_q == S_IDLE) && cmd_valid;
	assign mem_we     = cmd_pop && (cmd.op == OP_WRITE);
	assign hit        = eligible(rd_q, rn_iss_q);
	assign act_ev     = rd_q.flags[0];
	assign deact_ev   = is_tick_q && old_flags_q[1];

	always_comb begin
		rd_addr = IDX_W'(cur_q);
		case (state_q)
			S_IDLE: begin
				if (cmd.op == OP_PLAY) begin
					rd_addr = '0;
				end
			end
			S_TICK_RD: rd_addr = IDX_W'(tick_start.pos);
			S_SEARCH:  rd_addr = IDX_W'(nxt.pos);
			default:   rd_addr = IDX_W'(cur_q);
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[IDX_W'(cmd.index)] <= cmd.entry;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CNT_W'(1);
		end else if (cfg_we) begin
			if (cfg_wdata == '0) begin
				cnt_q <= CNT_W'(1);
			end else if (32'(cfg_wdata) > 32'(MAX_STEPS)) begin
				cnt_q <= CNT_W'(MAX_STEPS);
			end else begin
				cnt_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit_load) begin
			out_vld_q <= 1'b1;
		end else if (res_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_q <= pend0_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			playing_q   <= 1'b0;
			cur_q       <= '0;
			rn_q        <= '0;
			elapsed_q   <= '0;
			pos_iss_q   <= '0;
			rn_iss_q    <= '0;
			chk_q       <= '0;
			old_pos_q   <= '0;
			old_dur_q   <= '0;
			old_flags_q <= '0;
			is_tick_q   <= 1'b0;
			pend0_q     <= '0;
			pend1_q     <= '0;
			pend_n_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						case (cmd.op)
							OP_PLAY: begin
								if (!playing_q) begin
									playing_q <= 1'b1;
									rn_q      <= '0;
									elapsed_q <= '0;
									cur_q     <= '0;
									pos_iss_q <= '0;
									rn_iss_q  <= RN_W'(1);
									chk_q     <= '0;
									is_tick_q <= 1'b0;
									state_q   <= S_SEARCH;
								end
							end
							OP_STOP: begin
								if (playing_q) begin
									playing_q <= 1'b0;
									state_q   <= S_STOP_RD;
								end
							end
							OP_TICK: begin
								if (playing_q) begin
									if (elapsed_q != '1) begin
										elapsed_q <= elapsed_q + 1'b1;
									end
									state_q <= S_TICK_RD;
								end
							end
							default: ;
						endcase
					end
				end
				S_TICK_RD: begin
					if (elapsed_q > {1'b0, rd_q.dur}) begin
						old_pos_q   <= cur_q;
						old_dur_q   <= rd_q.dur;
						old_flags_q <= rd_q.flags;
						is_tick_q   <= 1'b1;
						pos_iss_q   <= tick_start.pos;
						rn_iss_q    <= tick_start.rn;
						chk_q       <= '0;
						state_q     <= S_SEARCH;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_STOP_RD: begin
					if (rd_q.flags[1]) begin
						pend0_q  <= '{kind: EV_DEACT, step: cur_q[STEP_W-1:0], rnum: rn_q,
							last: 1'b1};
						pend_n_q <= 2'd1;
						state_q  <= S_EMIT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_SEARCH: begin
					if (hit) begin
						cur_q <= pos_iss_q;
						rn_q  <= rn_iss_q;
						if (is_tick_q) begin
							elapsed_q <= elapsed_q - {1'b0, old_dur_q};
						end
						if (act_ev) begin
							pend0_q <= '{kind: EV_ACT, step: pos_iss_q[STEP_W-1:0],
								rnum: rn_iss_q, last: !deact_ev};
						end else begin
							pend0_q <= '{kind: EV_DEACT, step: old_pos_q[STEP_W-1:0],
								rnum: rn_iss_q, last: 1'b1};
						end
						pend1_q  <= '{kind: EV_DEACT, step: old_pos_q[STEP_W-1:0],
							rnum: rn_iss_q, last: 1'b1};
						pend_n_q <= {1'b0, act_ev} + {1'b0, deact_ev};
						state_q  <= (act_ev || deact_ev) ? S_EMIT : S_IDLE;
					end else if (chk_q == SL_W'(SEARCH_LIMIT - 1)) begin
						// search exhausted: stop and report the position reached
						cur_q     <= pos_iss_q;
						rn_q      <= rn_iss_q;
						playing_q <= 1'b0;
						pend0_q   <= '{kind: EV_NONE_FOUND, step: pos_iss_q[STEP_W-1:0],
							rnum: rn_iss_q, last: 1'b1};
						pend_n_q  <= 2'd1;
						state_q   <= S_EMIT;
					end else begin
						pos_iss_q <= nxt.pos;
						rn_iss_q  <= nxt.rn;
						chk_q     <= chk_q + 1'b1;
					end
				end
				S_EMIT: begin
					if (slot_free) begin
						pend0_q  <= pend1_q;
						pend_n_q <= pend_n_q - 1'b1;
						if (pend_n_q == 2'd1) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_valid = out_vld_q;
	assign res       = out_q;

	`RFSC_ASSERT_SAME(a_emit_count, clk, arst_n, state_q == S_EMIT,
		pend_n_q == 2'd1 || pend_n_q == 2'd2, "emit state without a pending event")
	`RFSC_ASSERT_SAME(a_cand_in_range, clk, arst_n, state_q == S_SEARCH,
		pos_iss_q < cnt_q, "search candidate beyond step count")
	`RFSC_ASSERT_SAME(a_stop_clears_play, clk, arst_n, state_q == S_STOP_RD,
		!playing_q, "still playing while stop is carried out")
	`RFSC_ASSERT_NEXT(a_exhaust_stops, clk, arst_n,
		state_q == S_SEARCH && !hit && chk_q == SL_W'(SEARCH_LIMIT - 1),
		!playing_q && state_q == S_EMIT, "exhausted search did not stop play")

endmodule

/* sim/round_filtered_step_chaser_core_test.sv */
// self-checking testbench of the step chaser core: directed table, random runs, event checks
module round_filtered_step_chaser_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import rfsc_pkg::*;

	localparam int          STEPS_MAX     = 16;
	localparam int          SCAN_LIMIT    = 256;
	localparam int          ROUND_CAP     = 32766;
	localparam int unsigned ELAPSED_TOP   = (1 << ELAPSED_W) - 1;
	localparam int          SETTLE_CYCLES = 400;
	localparam int          LONG_HOLD     = 400;
	localparam int          SAT_TICKS     = 32800;
	localparam int          CYCLE_LIMIT   = 4000000;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	logic [CNT_W-1:0] cfg_wdata = '0;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	logic [1:0]       s_tuser   = '0;
	logic [71:0]      s_tdata   = '0;
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	logic [1:0]       m_tuser;
	logic [23:0]      m_tdata;
	logic             m_tlast;

	round_filtered_step_chaser_core #(
		.MAX_STEPS   (STEPS_MAX),
		.SEARCH_LIMIT(SCAN_LIMIT)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// chaser state as the predictor sees it
	logic [DUR_W-1:0]        tbl_dur   [STEPS_MAX];
	logic signed [LIM_W-1:0] tbl_min   [STEPS_MAX];
	logic signed [LIM_W-1:0] tbl_exact [STEPS_MAX];
	logic signed [LIM_W-1:0] tbl_max   [STEPS_MAX];
	logic [1:0]              tbl_flags [STEPS_MAX];
	logic [CNT_W-1:0]        count_reg = 5'd1;
	int unsigned             cur_pos   = 0;
	int                      round_ctr = -1;
	int unsigned             elapsed   = 0;
	bit                      chaser_on = 1'b0;

	result_t step_events[$];
	result_t pending_events[$];

	typedef struct packed {
		cmd_t    cmd;
		int      n_ev;     // typed events, or -1 to take the predictor's
		result_t ev0;
		result_t ev1;
	} dir_row_t;
	dir_row_t dir_rows[$];

	int fail_count    = 0;
	int cycle_count   = 0;
	int hold_count    = 0;
	bit idle_on       = 1'b1;
	bit long_hold_req = 1'b0;

	function automatic int unsigned steps_in_use();
		if (count_reg == 0) return 1;
		if (count_reg > STEPS_MAX) return STEPS_MAX;
		return count_reg;
	endfunction

	function automatic bit step_allowed(int unsigned s, int r);
		return (tbl_min[s] == -1 || r >= tbl_min[s]) &&
			(tbl_exact[s] == -1 || r == tbl_exact[s]) &&
			(tbl_max[s] == -1 || r <= tbl_max[s]);
	endfunction

	function automatic void note_event(kind_t k, int unsigned s);
		result_t e;
		int rn;
		rn = round_ctr + 1;
		if (rn < 0) rn = 0;
		e.kind = k;
		e.step = s[STEP_W-1:0];
		e.rnum = rn[RN_W-1:0];
		e.last = 1'b0;
		step_events.push_back(e);
	endfunction

	// bounded scan for the next step whose round filter passes, moving on through rounds
	function automatic bit find_next_step(bit fresh);
		int unsigned p;
		p = cur_pos;
		for (int i = 0; i < SCAN_LIMIT; i++) begin
			if (fresh && i == 0) p = 0;
			else p = (p + 1) % steps_in_use();
			if (p == 0 && round_ctr < ROUND_CAP) round_ctr++;
			cur_pos = p;
			if (step_allowed(p, round_ctr + 1)) return 1'b1;
		end
		return 1'b0;
	endfunction

	// returns 0 when the command is ignored
	function automatic bit chaser_predict(cmd_t c);
		int unsigned old;
		bit acted;
		result_t e;
		step_events.delete();
		acted = 1'b1;
		case (c.op)
			OP_WRITE: begin
				tbl_dur[c.index]   = c.entry.dur;
				tbl_min[c.index]   = c.entry.min_r;
				tbl_exact[c.index] = c.entry.exact_r;
				tbl_max[c.index]   = c.entry.max_r;
				tbl_flags[c.index] = c.entry.flags;
			end
			OP_PLAY: begin
				if (chaser_on) begin
					acted = 1'b0;
				end else begin
					chaser_on = 1'b1;
					round_ctr = -1;
					elapsed   = 0;
					cur_pos   = 0;
					if (!find_next_step(1'b1)) begin
						chaser_on = 1'b0;
						note_event(EV_NONE_FOUND, cur_pos);
					end else if (tbl_flags[cur_pos][0]) begin
						note_event(EV_ACT, cur_pos);
					end
				end
			end
			OP_STOP: begin
				if (!chaser_on) begin
					acted = 1'b0;
				end else begin
					chaser_on = 1'b0;
					if (tbl_flags[cur_pos][1]) note_event(EV_DEACT, cur_pos);
				end
			end
			default: begin
				if (!chaser_on) begin
					acted = 1'b0;
				end else begin
					if (elapsed < ELAPSED_TOP) elapsed++;
					old = cur_pos;
					if (elapsed > tbl_dur[old]) begin
						if (!find_next_step(1'b0)) begin
							chaser_on = 1'b0;
							note_event(EV_NONE_FOUND, cur_pos);
						end else begin
							// overshoot carries into the new step
							elapsed -= tbl_dur[old];
							if (tbl_flags[cur_pos][0]) note_event(EV_ACT, cur_pos);
							if (tbl_flags[old][1]) note_event(EV_DEACT, old);
						end
					end
				end
			end
		endcase
		if (step_events.size() != 0) begin
			e = step_events.pop_back();
			e.last = 1'b1;
			step_events.push_back(e);
		end
		return acted;
	endfunction

	function automatic result_t ev(kind_t k, int s, int r, bit l);
		result_t e;
		e.kind = k;
		e.step = s;
		e.rnum = r;
		e.last = l;
		return e;
	endfunction

	function automatic void dir_row(op_t op, int idx, int dur, int mn, int ex, int mx,
			int fl, int n, result_t e0 = '0, result_t e1 = '0);
		dir_row_t r;
		r.cmd.op            = op;
		r.cmd.index         = idx;
		r.cmd.entry.dur     = dur;
		r.cmd.entry.min_r   = mn;
		r.cmd.entry.exact_r = ex;
		r.cmd.entry.max_r   = mx;
		r.cmd.entry.flags   = fl;
		r.n_ev              = n;
		r.ev0               = e0;
		r.ev1               = e1;
		dir_rows.push_back(r);
	endfunction

	function automatic logic [LIM_W-1:0] rand_limit();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return NO_LIMIT;
			6, 7: return $urandom_range(1, 8);
			8: return $urandom_range(0, 16'h7fff);
			default: return $urandom_range(0, 16'hffff);
		endcase
	endfunction

	function automatic entry_t random_entry();
		entry_t e;
		case ($urandom_range(0, 19))
			0: e.dur = $urandom_range(0, 16'hffff);
			1, 2, 3: e.dur = $urandom_range(0, 20);
			default: e.dur = $urandom_range(0, 3);
		endcase
		e.min_r   = rand_limit();
		e.exact_r = ($urandom_range(0, 2) == 0) ? rand_limit() : NO_LIMIT;
		e.max_r   = rand_limit();
		e.flags   = $urandom_range(0, 3);
		return e;
	endfunction

	// mostly play, run a while, stop; the rest is noise
	function automatic cmd_t random_cmd();
		cmd_t c;
		int pick;
		c.index = $urandom_range(0, 15);
		c.entry = random_entry();
		pick = $urandom_range(0, 99);
		if (chaser_on) begin
			if (pick < 76) c.op = OP_TICK;
			else if (pick < 86) c.op = OP_WRITE;
			else if (pick < 94) c.op = OP_STOP;
			else c.op = OP_PLAY;
		end else begin
			if (pick < 45) c.op = OP_PLAY;
			else if (pick < 70) c.op = OP_WRITE;
			else if (pick < 85) c.op = OP_TICK;
			else c.op = OP_STOP;
		end
		return c;
	endfunction

	task automatic send_cmd(input cmd_t c, input int n_typed, input result_t t0,
			input result_t t1, output bit acted);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= c.op;
		s_tdata  <= {2'b00, c.entry.flags[1], c.entry.flags[0], c.entry.max_r,
			c.entry.exact_r, c.entry.min_r, c.entry.dur, c.index};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		acted = chaser_predict(c);
		if (n_typed < 0) begin
			foreach (step_events[i]) pending_events.push_back(step_events[i]);
		end else begin
			if (n_typed >= 1) pending_events.push_back(t0);
			if (n_typed >= 2) pending_events.push_back(t1);
		end
	endtask

	// wait for every event, then let the engine finish any silent work
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_count(input int v);
		cfg_wdata <= v;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
		count_reg = v;
	endtask

	task automatic run_phase(input int cnt, input bit idle, input bit squeeze, input int items);
		cmd_t c;
		bit acted;
		int done;
		settle();
		set_count(cnt);
		idle_on = idle;
		if (squeeze) long_hold_req = 1'b1;
		done = 0;
		while (done < items) begin
			c = random_cmd();
			send_cmd(c, -1, '0, '0, acted);
			if (acted) done++;
		end
	endtask

	initial begin : receiver
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				m_tready <= 1'b0;
				for (hold_count = 0; hold_count < LONG_HOLD; hold_count++) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin : check_events
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_events.size() == 0) begin
				$error("unexpected event: event_kind %0d event_step %0d round_number %0d",
					m_tuser, m_tdata[3:0], m_tdata[18:4]);
				fail_count++;
			end else begin
				want = pending_events.pop_front();
				if (m_tuser != want.kind) begin
					$error("event_kind expected %0d actual %0d", want.kind, m_tuser);
					fail_count++;
				end
				if (m_tdata[3:0] != want.step) begin
					$error("event_step expected %0d actual %0d", want.step, m_tdata[3:0]);
					fail_count++;
				end
				if (m_tdata[18:4] != want.rnum) begin
					$error("round_number expected %0d actual %0d", want.rnum, m_tdata[18:4]);
					fail_count++;
				end
				if (m_tlast != want.last) begin
					$error("last expected %0d actual %0d", want.last, m_tlast);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin : stimulus
		cmd_t c;
		bit acted;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ignored while stopped
		dir_row(OP_TICK, 0, 0, 0, 0, 0, 0, 0);
		dir_row(OP_STOP, 0, 0, 0, 0, 0, 0, 0);
		dir_row(OP_WRITE, 0, 2, -1, -1, -1, 3, 0);
		dir_row(OP_WRITE, 15, 16'hffff, 32767, 32767, 32767, 0, 0);
		dir_row(OP_PLAY, 0, 0, 0, 0, 0, 0, 1, ev(EV_ACT, 0, 1, 1'b1));
		dir_row(OP_PLAY, 0, 0, 0, 0, 0, 0, 0);
		dir_row(OP_TICK, 0, 0, 0, 0, 0, 0, 0);
		dir_row(OP_TICK, 0, 0, 0, 0, 0, 0, 0);
		// third tick overruns the hold time and wraps into round two
		dir_row(OP_TICK, 0, 0, 0, 0, 0, 0, 2, ev(EV_ACT, 0, 2, 1'b0), ev(EV_DEACT, 0, 2, 1'b1));
		dir_row(OP_STOP, 0, 0, 0, 0, 0, 0, 1, ev(EV_DEACT, 0, 2, 1'b1));
		dir_row(OP_STOP, 0, 0, 0, 0, 0, 0, 0);
		dir_row(OP_TICK, 0, 0, 0, 0, 0, 0, 0);
		// max round 0 never passes, the scan runs out
		dir_row(OP_WRITE, 0, 0, -1, -1, 0, 3, 0);
		dir_row(OP_PLAY, 0, 0, 0, 0, 0, 0, 1, ev(EV_NONE_FOUND, 0, 256, 1'b1));
		dir_row(OP_TICK, 0, 0, 0, 0, 0, 0, 0);
		dir_row(OP_WRITE, 0, 0, 3, -1, 4, 1, 0);
		dir_row(OP_PLAY, 0, 0, 0, 0, 0, 0, -1);
		dir_row(OP_TICK, 0, 0, 0, 0, 0, 0, -1);
		dir_row(OP_TICK, 0, 0, 0, 0, 0, 0, -1);
		dir_row(OP_WRITE, 0, 1, -1, 2, -1, 2, 0);
		dir_row(OP_PLAY, 0, 0, 0, 0, 0, 0, -1);
		dir_row(OP_TICK, 0, 0, 0, 0, 0, 0, -1);
		dir_row(OP_TICK, 0, 0, 0, 0, 0, 0, -1);
		dir_row(OP_WRITE, 0, 0, -1, -1, -1, 2, 0);
		dir_row(OP_PLAY, 0, 0, 0, 0, 0, 0, 0);
		dir_row(OP_STOP, 0, 0, 0, 0, 0, 0, 1, ev(EV_DEACT, 0, 1, 1'b1));
		foreach (dir_rows[i])
			send_cmd(dir_rows[i].cmd, dir_rows[i].n_ev, dir_rows[i].ev0, dir_rows[i].ev1, acted);

		// every entry written before a larger step count can reach it
		settle();
		for (int i = 0; i < STEPS_MAX; i++) begin
			c.op    = OP_WRITE;
			c.index = i;
			c.entry = random_entry();
			send_cmd(c, -1, '0, '0, acted);
		end

		run_phase(16, 1'b1, 1'b0, 160);
		run_phase(0, 1'b1, 1'b0, 140);
		run_phase(31, 1'b1, 1'b1, 160);
		run_phase(3, 1'b0, 1'b0, 140);
		run_phase(17, 1'b1, 1'b0, 140);
		run_phase(2, 1'b1, 1'b0, 140);

		// one-step loop, one round per tick, until the round number saturates
		settle();
		set_count(1);
		idle_on = 1'b0;
		c = '0;
		c.op = OP_STOP;
		send_cmd(c, -1, '0, '0, acted);
		c.op            = OP_WRITE;
		c.entry.min_r   = NO_LIMIT;
		c.entry.exact_r = NO_LIMIT;
		c.entry.max_r   = NO_LIMIT;
		c.entry.flags   = 2'b11;
		send_cmd(c, -1, '0, '0, acted);
		c.op = OP_PLAY;
		send_cmd(c, -1, '0, '0, acted);
		c.op = OP_TICK;
		repeat (SAT_TICKS) send_cmd(c, -1, '0, '0, acted);
		c.op = OP_STOP;
		send_cmd(c, -1, '0, '0, acted);

		run_phase(5, 1'b0, 1'b0, 150);
		settle();
		if (fail_count == 0 && pending_events.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
